// ----- sv/tkr_pkg.sv -----
// ----------------------------------------------------------------------------
// tkr_pkg
// Shared types, constants and slot decode for the two-wire key event reader.
// ----------------------------------------------------------------------------
package tkr_pkg;

    localparam int unsigned SLOT_W = 6;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned COLS_W = 5;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd1250;
    localparam logic [COLS_W-1:0] COLS_RESET  = 5'd8;

    // register index, taken from paddr[2]
    localparam logic REG_ACTION_TICKS = 1'b0;
    localparam logic REG_COLUMNS      = 1'b1;

    // slot codes
    localparam logic [SLOT_W-1:0] SLOT_START     = 6'd0;
    localparam logic [SLOT_W-1:0] SLOT_CLK_HI    = 6'd1;
    localparam logic [SLOT_W-1:0] SLOT_DATA_LO   = 6'd2;
    localparam logic [SLOT_W-1:0] SLOT_CLK_LO    = 6'd3;
    localparam logic [SLOT_W-1:0] SLOT_RELEASE   = 6'd4;
    localparam logic [SLOT_W-1:0] SLOT_TURN_HI   = 6'd5;
    localparam logic [SLOT_W-1:0] SLOT_BIT_FIRST = 6'd6;
    localparam logic [SLOT_W-1:0] SLOT_BIT_LAST  = 6'd21;
    localparam logic [SLOT_W-1:0] SLOT_ACK_START = 6'd22;
    localparam logic [SLOT_W-1:0] SLOT_ACK_LO    = 6'd23;
    localparam logic [SLOT_W-1:0] SLOT_ACK_CLK   = 6'd24;
    localparam logic [SLOT_W-1:0] SLOT_STOP      = 6'd25;
    localparam logic [SLOT_W-1:0] SLOT_COUNT     = 6'd26;

    localparam logic [7:0] RELEASE_BIT = 8'h80;
    localparam logic [7:0] NIBBLE_MASK = 8'h0f;
    localparam logic [2:0] ROW_MASK    = 3'h7;

    typedef struct packed {
        logic clock;
        logic data;
        logic drive;
    } pins_t;

    localparam pins_t PINS_RESET = '{clock: 1'b1, data: 1'b1, drive: 1'b0};

    typedef struct packed {
        pins_t      pins;
        logic       event_valid;
        logic       key_released;
        logic [2:0] key_row;
        logic [3:0] key_column;
        logic [6:0] scan_index;
    } result_t;

    function automatic logic is_sample_slot(input logic [SLOT_W-1:0] s);
        return (s >= SLOT_BIT_FIRST) && (s <= SLOT_BIT_LAST) && !s[0];
    endfunction

    function automatic pins_t apply_slot(input pins_t p, input logic [SLOT_W-1:0] s);
        pins_t q;
        q = p;
        case (s)
            SLOT_START, SLOT_ACK_START:
            begin
                q.drive = 1'b1;
                q.data  = 1'b1;
            end
            SLOT_DATA_LO, SLOT_ACK_LO:
            begin
                q.data = 1'b0;
            end
            SLOT_RELEASE:
            begin
                q.drive = 1'b0;
            end
            SLOT_STOP:
            begin
                q.drive = 1'b0;
                q.clock = 1'b1;
            end
            SLOT_CLK_LO, SLOT_ACK_CLK:
            begin
                q.clock = 1'b0;
            end
            default:
            begin
                q.clock = !is_sample_slot(s);
            end
        endcase
        return q;
    endfunction

endpackage

// ----- sv/tkr_seq.sv -----
// ----------------------------------------------------------------------------
// tkr_seq
// Slot sequencer: pin actions, bit sampling and key decode, one tick per word.
// ----------------------------------------------------------------------------
module tkr_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          irq_level,
    input  logic                          data_level,
    input  logic [tkr_pkg::TICK_W-1:0]    action_ticks,
    input  logic [tkr_pkg::COLS_W-1:0]    columns,
    output tkr_pkg::result_t              result
);
    import tkr_pkg::*;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [7:0]        byte_reg, byte_next;
    logic              busy_reg, busy_next;
    logic              last_irq_reg, last_irq_next;
    pins_t             pins_reg, pins_next;

    logic [TICK_W-1:0] tick_inc;
    logic [SLOT_W-1:0] slot_inc;
    logic [SLOT_W-1:0] bit_offset;
    logic              done;
    logic [3:0]        col;
    logic [2:0]        row;
    logic [7:0]        product;
    logic [7:0]        scan_sum;

    always_comb
    begin
        tick_inc      = tick_reg + 16'd1;
        slot_inc      = slot_reg + 6'd1;
        bit_offset    = slot_reg - SLOT_BIT_FIRST;
        slot_next     = slot_reg;
        tick_next     = tick_reg;
        byte_next     = byte_reg;
        busy_next     = busy_reg;
        pins_next     = pins_reg;
        last_irq_next = irq_level;
        done          = 1'b0;
        if (!busy_reg)
        begin
            if (last_irq_reg && !irq_level)
            begin
                busy_next = 1'b1;
                slot_next = SLOT_START;
                tick_next = '0;
                byte_next = '0;
                pins_next = apply_slot(pins_reg, SLOT_START);
            end
        end
        else
        begin
            tick_next = tick_inc;
            if (tick_inc >= action_ticks)
            begin
                if (is_sample_slot(slot_reg) && data_level)
                begin
                    byte_next = byte_reg | (RELEASE_BIT >> bit_offset[3:1]);
                end
                tick_next = '0;
                if (slot_inc >= SLOT_COUNT)
                begin
                    busy_next = 1'b0;
                    slot_next = SLOT_START;
                    done      = 1'b1;
                end
                else
                begin
                    slot_next = slot_inc;
                    pins_next = apply_slot(pins_reg, slot_inc);
                end
            end
        end
    end

    // key decode; the last data bit lands well before the stop slot
    always_comb
    begin
        row      = byte_reg[6:4] & ROW_MASK;
        col      = byte_reg[3:0] & NIBBLE_MASK[3:0];
        if (col != 4'd0)
        begin
            col = col - 4'd1;
        end
        product  = {5'd0, row} * {3'd0, columns};
        scan_sum = product + {4'd0, col};

        result.pins         = pins_next;
        result.event_valid  = done;
        result.key_released = done & |(byte_reg & RELEASE_BIT);
        result.key_row      = done ? row : 3'd0;
        result.key_column   = done ? col : 4'd0;
        result.scan_index   = done ? scan_sum[6:0] : 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= SLOT_START;
            tick_reg     <= '0;
            byte_reg     <= '0;
            busy_reg     <= 1'b0;
            last_irq_reg <= 1'b1;
            pins_reg     <= PINS_RESET;
        end
        else if (step)
        begin
            slot_reg     <= slot_next;
            tick_reg     <= tick_next;
            byte_reg     <= byte_next;
            busy_reg     <= busy_next;
            last_irq_reg <= last_irq_next;
            pins_reg     <= pins_next;
        end
    end

endmodule

// ----- sv/two_wire_key_event_reader.sv -----
// ----------------------------------------------------------------------------
// two_wire_key_event_reader
// Host-clocked two-wire keypad reader with APB configuration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per clock tick of the pin
//   sampler, carrying irq_level and data_level. A falling irq edge while idle
//   starts a 26-slot read, each slot action_ticks words long.
//   Output channel (out_valid/out_ready): one word per input word with the
//   pin levels to drive and, on the word that ends a read, the key event.
//   Each accepted input word passes through the output register to out_valid; one word is taken
//   every cycle while the receiver keeps out_ready high.
//   The output register plus a one-word skid stage decouple the sides: when
//   the receiver stalls, one more word is accepted, then in_ready drops until
//   the output drains.
//   APB: action_ticks at 0x0, columns at 0x4; pready is always high.
//   Reset: idle, clock high, data released, action_ticks 1250, columns 8,
//   both words empty.
// ----------------------------------------------------------------------------
module two_wire_key_event_reader
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          irq_level,
    input  logic                          data_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          clock_out,
    output logic                          data_out,
    output logic                          data_drive,
    output logic                          event_valid,
    output logic                          key_released,
    output logic [2:0]                    key_row,
    output logic [3:0]                    key_column,
    output logic [6:0]                    scan_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tkr_pkg::APB_AW-1:0]    paddr,
    input  logic [tkr_pkg::APB_DW-1:0]    pwdata,
    output logic [tkr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import tkr_pkg::*;

    logic [TICK_W-1:0] action_ticks_reg;
    logic [COLS_W-1:0] columns_reg;
    logic              cfg_write;
    logic              reg_sel;

    logic    in_fire;
    logic    out_fire;
    result_t seq_result;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    // configuration
    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_AW-1];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        case (reg_sel)
            REG_ACTION_TICKS: prdata = {{(APB_DW-TICK_W){1'b0}}, action_ticks_reg};
            REG_COLUMNS:      prdata = {{(APB_DW-COLS_W){1'b0}}, columns_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_ticks_reg <= TICKS_RESET;
            columns_reg      <= COLS_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_ACTION_TICKS)
            begin
                action_ticks_reg <= pwdata[TICK_W-1:0];
            end
            else
            begin
                columns_reg <= pwdata[COLS_W-1:0];
            end
        end
    end

    // sequencer
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid & in_ready;
    assign out_fire = out_valid_reg & out_ready;

    tkr_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_fire),
        .irq_level    (irq_level),
        .data_level   (data_level),
        .action_ticks (action_ticks_reg),
        .columns      (columns_reg),
        .result       (seq_result)
    );

    // output word and skid word
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = seq_result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = seq_result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign clock_out    = out_reg.pins.clock;
    assign data_out     = out_reg.pins.data;
    assign data_drive   = out_reg.pins.drive;
    assign event_valid  = out_reg.event_valid;
    assign key_released = out_reg.key_released;
    assign key_row      = out_reg.key_row;
    assign key_column   = out_reg.key_column;
    assign scan_index   = out_reg.scan_index;

endmodule

// ----- sv/tkr_checker.sv -----
// ----------------------------------------------------------------------------
// tkr_checker
// Port-level checks for the two-wire key event reader.
// ----------------------------------------------------------------------------
module tkr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       clock_out,
    input logic       data_out,
    input logic       data_drive,
    input logic       event_valid,
    input logic       key_released,
    input logic [2:0] key_row,
    input logic [3:0] key_column,
    input logic [6:0] scan_index
);

    // key fields stay clear outside an event
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |->
            !key_released && key_row == 3'd0 && key_column == 4'd0 && scan_index == 7'd0)
        else $error("key fields set without event");

    // a read ends with the clock high and data released
    a_event_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid |-> clock_out && !data_drive)
        else $error("event word with bus not released");

    // column is nibble minus one (a zero nibble gives zero), never all ones
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_column != 4'hf)
        else $error("key column out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable({clock_out, data_out, data_drive, event_valid,
                                  key_released, key_row, key_column, scan_index}))
        else $error("output word changed while stalled");

endmodule

bind two_wire_key_event_reader tkr_checker u_tkr_checker (.*);
